// ----- design/gsp_pkg.sv -----
// gsp_pkg: request codes, controller states and fixed output widths
// for the shortest-path engine; no dependencies
package gsp_pkg;

  localparam int NODE_BITS = 5;
  localparam int DIST_OUT_BITS = 21;
  localparam int PATH_MAX = 32;
  localparam int PATH_IDX_BITS = 5;

  typedef enum logic [2:0] {
    REQ_ADD_NODE = 3'd0,
    REQ_DEL_NODE = 3'd1,
    REQ_SET_EDGE = 3'd2,
    REQ_DEL_EDGE = 3'd3,
    REQ_QUERY    = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DEL_NODE,
    ST_EDGE,
    ST_INIT,
    ST_RELAX,
    ST_CHECK,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_MISS
  } state_t;

endpackage

// ----- design/gsp_ram.sv -----
// gsp_ram: simple dual-port memory, one write and one registered read per cycle
// no dependencies
module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/graph_shortest_path_engine.sv -----
// graph_shortest_path_engine: graph edit and single-source shortest-path query
// depends on gsp_pkg and gsp_ram
//
//  channel  direction  signals
//  in       sink       in_valid, in_ready, req_type, node_a, node_b, edge_weight
//  out      source     out_valid, out_ready, path_node, path_distance, found, last
//
// removing a node clears its row and column of the edge memory, and clear sweeps
// the whole edge memory; the engine holds up to min(NODES, 32) nodes. a query
// makes one relax pass per settled node through the edge memory read port,
// then walks the path and gives one result beat per path node.
// after reset the edge memory is swept before in_ready rises.
// a pending result beat does not block new requests, only the next result.
module graph_shortest_path_engine #(
  parameter int NODES = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     req_type,
  input  logic [4:0]                     node_a,
  input  logic [4:0]                     node_b,
  input  logic [15:0]                    edge_weight,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gsp_pkg::NODE_BITS-1:0]  path_node,
  output logic [gsp_pkg::DIST_OUT_BITS-1:0] path_distance,
  output logic                           found,
  output logic                           last
);
  import gsp_pkg::*;

  localparam int LIVE = (NODES < 32) ? NODES : 32;
  localparam int IDXW = $clog2(LIVE);
  localparam int AW = $clog2(LIVE * LIVE);
  localparam int CNTW = AW + 1;
  localparam int DW = WEIGHT_BITS + IDXW;
  localparam int WIN = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int SW = (DW > DIST_OUT_BITS) ? DW : DIST_OUT_BITS;
  localparam int EW = WEIGHT_BITS + 1;

  function automatic logic [AW-1:0] eaddr(input logic [IDXW-1:0] x,
                                          input logic [IDXW-1:0] y);
    eaddr = AW'(int'(x) * LIVE + int'(y));
  endfunction

  state_t state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [LIVE-1:0] present, present_next;
  logic [IDXW-1:0] ra, ra_next, rb, rb_next;
  logic [WEIGHT_BITS-1:0] rw, rw_next;
  logic [LIVE-1:0] reached, reached_next, settled, settled_next;
  logic [IDXW-1:0] pick, pick_next;
  logic [DW-1:0] pick_dist, pick_dist_next;
  logic [IDXW:0] iss, iss_next;
  logic pv, pv_next;
  logic [IDXW-1:0] pn, pn_next;
  logic any_c, any_c_next;
  logic [IDXW-1:0] min_n, min_n_next;
  logic [DW-1:0] min_d, min_d_next;
  logic [IDXW-1:0] cur, cur_next;
  logic [PATH_IDX_BITS:0] pcount, pcount_next;
  logic [PATH_IDX_BITS-1:0] oidx, oidx_next;
  logic out_valid_next;
  logic [NODE_BITS-1:0] path_node_next;
  logic [DIST_OUT_BITS-1:0] path_distance_next;
  logic found_next, last_next;

  // memory ports
  logic e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic d_we;
  logic [IDXW-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic p_we;
  logic [IDXW-1:0] p_waddr, p_raddr;
  logic [IDXW-1:0] p_wdata, p_rdata;
  logic b_we;
  logic [PATH_IDX_BITS-1:0] b_waddr, b_raddr;
  logic [IDXW+DW-1:0] b_wdata, b_rdata;

  logic a_ok, b_ok, accept, slot_free;
  logic [IDXW-1:0] ai, bi;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [DW-1:0] nd, newd;
  logic relax_cond, cand;
  logic [SW-1:0] sat_wide;
  logic [DIST_OUT_BITS-1:0] sat_dist;

  gsp_ram #(.WIDTH(EW), .DEPTH(LIVE * LIVE)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );
  gsp_ram #(.WIDTH(DW), .DEPTH(LIVE)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );
  gsp_ram #(.WIDTH(IDXW), .DEPTH(LIVE)) u_pred (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  gsp_ram #(.WIDTH(IDXW + DW), .DEPTH(PATH_MAX)) u_path (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  assign ai = node_a[IDXW-1:0];
  assign bi = node_b[IDXW-1:0];
  assign a_ok = (32'(node_a) < 32'(LIVE)) && present[ai];
  assign b_ok = (32'(node_b) < 32'(LIVE)) && present[bi];
  assign w_in = WEIGHT_BITS'(edge_weight[WIN-1:0]);
  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // relax datapath for the node whose reads were issued last cycle
  assign nd = pick_dist + DW'(e_rdata[WEIGHT_BITS-1:0]);
  assign relax_cond = e_rdata[WEIGHT_BITS] && !settled[pn] &&
                      (!reached[pn] || (nd < d_rdata));
  assign newd = relax_cond ? nd : d_rdata;
  assign cand = (reached[pn] || relax_cond) && !settled[pn];

  assign sat_wide = SW'(b_rdata[DW-1:0]);
  assign sat_dist = (sat_wide > SW'((1 << DIST_OUT_BITS) - 1)) ? '1
                    : sat_wide[DIST_OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      cnt <= '0;
      present <= '0;
      out_valid <= 1'b0;
      pv <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      present <= present_next;
      out_valid <= out_valid_next;
      pv <= pv_next;
    end
    ra <= ra_next;
    rb <= rb_next;
    rw <= rw_next;
    reached <= reached_next;
    settled <= settled_next;
    pick <= pick_next;
    pick_dist <= pick_dist_next;
    iss <= iss_next;
    pn <= pn_next;
    any_c <= any_c_next;
    min_n <= min_n_next;
    min_d <= min_d_next;
    cur <= cur_next;
    pcount <= pcount_next;
    oidx <= oidx_next;
    path_node <= path_node_next;
    path_distance <= path_distance_next;
    found <= found_next;
    last <= last_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    present_next = present;
    ra_next = ra;
    rb_next = rb;
    rw_next = rw;
    reached_next = reached;
    settled_next = settled;
    pick_next = pick;
    pick_dist_next = pick_dist;
    iss_next = iss;
    pv_next = 1'b0;
    pn_next = pn;
    any_c_next = any_c;
    min_n_next = min_n;
    min_d_next = min_d;
    cur_next = cur;
    pcount_next = pcount;
    oidx_next = oidx;
    out_valid_next = (out_valid && out_ready) ? 1'b0 : out_valid;
    path_node_next = path_node;
    path_distance_next = path_distance;
    found_next = found;
    last_next = last;

    e_we = 1'b0;
    e_waddr = cnt[AW-1:0];
    e_wdata = '0;
    e_raddr = eaddr(pick, iss[IDXW-1:0]);
    d_we = 1'b0;
    d_waddr = pn;
    d_wdata = nd;
    d_raddr = iss[IDXW-1:0];
    p_we = 1'b0;
    p_waddr = pn;
    p_wdata = pick;
    p_raddr = cur;
    b_we = 1'b0;
    b_waddr = pcount[PATH_IDX_BITS-1:0];
    b_wdata = {cur, d_rdata};
    b_raddr = oidx;

    case (state)
      ST_SWEEP: begin
        e_we = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(LIVE * LIVE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ra_next = ai;
          rb_next = bi;
          rw_next = w_in;
          cnt_next = '0;
          case (req_type)
            REQ_ADD_NODE: begin
              if (32'(node_a) < 32'(LIVE)) begin
                present_next[ai] = 1'b1;
              end
            end
            REQ_DEL_NODE: begin
              if (a_ok) begin
                present_next[ai] = 1'b0;
                state_next = ST_DEL_NODE;
              end
            end
            REQ_SET_EDGE, REQ_DEL_EDGE: begin
              if (a_ok && b_ok) begin
                if (req_type == REQ_DEL_EDGE) begin
                  rw_next = '0;
                end
                cnt_next = {{(CNTW-1){1'b0}}, (req_type == REQ_SET_EDGE)};
                state_next = ST_EDGE;
              end
            end
            REQ_QUERY: begin
              state_next = (a_ok && b_ok) ? ST_INIT : ST_MISS;
            end
            REQ_CLEAR: begin
              present_next = '0;
              state_next = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DEL_NODE: begin
        // alternate the (a,n) and (n,a) entries
        e_we = 1'b1;
        e_waddr = cnt[0] ? eaddr(cnt[IDXW:1], ra) : eaddr(ra, cnt[IDXW:1]);
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(2 * LIVE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE: begin
        // cnt[0] carries the present bit, cnt[1] the direction
        e_we = 1'b1;
        e_waddr = cnt[1] ? eaddr(rb, ra) : eaddr(ra, rb);
        e_wdata = {cnt[0], rw};
        cnt_next = cnt + 2'd2;
        if (cnt[1]) begin
          state_next = ST_IDLE;
        end
      end
      ST_INIT: begin
        d_we = 1'b1;
        d_waddr = ra;
        d_wdata = '0;
        p_we = 1'b1;
        p_waddr = ra;
        p_wdata = ra;
        reached_next = '0;
        reached_next[ra] = 1'b1;
        settled_next = '0;
        settled_next[ra] = 1'b1;
        pick_next = ra;
        pick_dist_next = '0;
        iss_next = '0;
        any_c_next = 1'b0;
        state_next = ST_RELAX;
      end
      ST_RELAX: begin
        if (iss != (IDXW+1)'(LIVE)) begin
          pv_next = 1'b1;
          pn_next = iss[IDXW-1:0];
          iss_next = iss + 1'b1;
        end
        if (pv) begin
          d_we = relax_cond;
          p_we = relax_cond;
          if (relax_cond) begin
            reached_next[pn] = 1'b1;
          end
          if (cand && (!any_c || newd < min_d)) begin
            any_c_next = 1'b1;
            min_n_next = pn;
            min_d_next = newd;
          end
        end else if (iss == (IDXW+1)'(LIVE)) begin
          // pass done: settle the best candidate or stop
          if (any_c) begin
            pick_next = min_n;
            pick_dist_next = min_d;
            settled_next[min_n] = 1'b1;
            any_c_next = 1'b0;
            iss_next = '0;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cur_next = rb;
        pcount_next = '0;
        state_next = reached[rb] ? ST_WALK_RD : ST_MISS;
      end
      ST_WALK_RD: begin
        d_raddr = cur;
        state_next = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        b_we = 1'b1;
        pcount_next = pcount + 1'b1;
        if (cur == ra || pcount == (PATH_IDX_BITS+1)'(PATH_MAX - 1)) begin
          oidx_next = pcount[PATH_IDX_BITS-1:0];
          state_next = ST_OUT_RD;
        end else begin
          cur_next = p_rdata;
          state_next = ST_WALK_RD;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          path_node_next = NODE_BITS'(b_rdata[IDXW+DW-1:DW]);
          path_distance_next = sat_dist;
          found_next = 1'b1;
          last_next = (oidx == '0);
          if (oidx == '0) begin
            state_next = ST_IDLE;
          end else begin
            oidx_next = oidx - 1'b1;
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_MISS: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          path_node_next = '0;
          path_distance_next = '0;
          found_next = 1'b0;
          last_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
